>>> rtl/axis_deadzone_curve_shaper_top_defines.svh
// Assertion macros for the axis deadzone and curve shaper.
`ifndef AXIS_DEADZONE_CURVE_SHAPER_TOP_DEFINES_SVH
`define AXIS_DEADZONE_CURVE_SHAPER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ADCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ADCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ADCS_ASSERT_IMPL(lbl, ante, cons, msg)
`define ADCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/adcs_pkg.sv
// Package: payload types, register codes, constants and curve table builders.
package adcs_pkg;

  localparam int SAMPLE_BITS         = 16;
  localparam int CURVE_TABLE_ENTRIES = 256;
  localparam int TAB_LEN             = CURVE_TABLE_ENTRIES + 1;
  localparam int IDX_W               = $clog2(TAB_LEN);
  localparam int POS_W               = 16 + IDX_W;
  localparam int TAB_W               = 18;
  localparam int FULL_SCALE          = 1 << (SAMPLE_BITS - 1);
  localparam int MAX_MAG             = FULL_SCALE - 1;

  // Register reset values
  localparam logic [15:0] DEADZONE_RST    = 16'd0;
  localparam logic [15:0] SENSITIVITY_RST = 16'd20480;
  localparam logic [15:0] CURVE_EXP_RST   = 16'd4819;
  localparam logic        CURVE_EN_RST    = 1'b1;

  typedef enum logic [2:0] {
    CFG_DEADZONE    = 3'd0,
    CFG_SENSITIVITY = 3'd1,
    CFG_CURVE_EXP   = 3'd2,
    CFG_CURVE_EN    = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] axis_value;
    logic [3:0]                    axis_index;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] shaped_value;
    logic [3:0]                    axis_tag;
    logic                          clipped;
  } out_item_t;

  // Integer square root, used while building the exp table
  function automatic logic [63:0] isqrt64(logic [63:0] x_in);
    logic [63:0] x, res, bit_v;
    x     = x_in;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (bit_v != 0) begin
        if (x >= res + bit_v) begin
          x   = x - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/N) in Q.16
  function automatic logic [TAB_W-1:0] log_entry(int i);
    logic [63:0] x, res, ii;
    ii = 64'(i);
    if (i == CURVE_TABLE_ENTRIES) return TAB_W'(65536);
    x   = (64'd1 << 30) + ((ii << 30) / CURVE_TABLE_ENTRIES);
    res = '0;
    for (int j = 0; j < 20; j++) begin
      x   = (x * x) >> 30;
      res = res << 1;
      if (x >= (64'd1 << 31)) begin
        res = res | 64'd1;
        x   = x >> 1;
      end
    end
    return TAB_W'((res + 64'd8) >> 4);
  endfunction

  // 2^(i/N) in Q.16
  function automatic logic [TAB_W-1:0] exp_entry(int i);
    logic [63:0] roots [24];
    logic [63:0] q, v, ii;
    ii = 64'(i);
    if (i == CURVE_TABLE_ENTRIES) return TAB_W'(131072);
    roots[0] = isqrt64(64'd1 << 61);
    for (int j = 1; j < 24; j++) roots[j] = isqrt64(roots[j-1] << 30);
    q = (ii << 24) / CURVE_TABLE_ENTRIES;
    v = 64'd1 << 30;
    for (int j = 0; j < 24; j++) begin
      if (q[23-j]) v = (v * roots[j]) >> 30;
    end
    return TAB_W'((v + (64'd1 << 13)) >> 14);
  endfunction

  // Table row for a Q.16 fraction
  function automatic logic [IDX_W-1:0] tab_idx(logic [15:0] frac);
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] idx;
    pos = POS_W'(frac) * POS_W'(CURVE_TABLE_ENTRIES);
    idx = pos >> 16;
    if (idx >= POS_W'(CURVE_TABLE_ENTRIES)) idx = POS_W'(CURVE_TABLE_ENTRIES - 1);
    return IDX_W'(idx);
  endfunction

  // Interpolation weight for a Q.16 fraction
  function automatic logic [15:0] tab_wt(logic [15:0] frac);
    logic [POS_W-1:0] pos;
    pos = POS_W'(frac) * POS_W'(CURVE_TABLE_ENTRIES);
    return pos[15:0];
  endfunction

  // Linear interpolation between two neighboring entries, truncating
  function automatic logic [TAB_W-1:0] interp(logic [TAB_W-1:0] a, logic [TAB_W-1:0] b,
                                              logic [15:0] w);
    logic [TAB_W-1:0] bb;
    logic [TAB_W+15:0] prod;
    bb   = (b < a) ? a : b;
    prod = (TAB_W+16)'(bb - a) * (TAB_W+16)'(w);
    return TAB_W'(a + TAB_W'(prod >> 16));
  endfunction

endpackage

>>> rtl/axis_deadzone_curve_shaper_top.sv
// An accepted input transaction moves through the pipeline stage registers into the output register.
// Throughput: one transaction per cycle; a 17-stage restoring divider and two table lookups
// are laid out as pipeline stages, and the whole pipe holds while the output is stalled.
// Reset: asynchronous, active low; clears all valid bits and loads the register defaults.
// The log2 and exp2 tables are constant logic and need no clearing pass.
`include "axis_deadzone_curve_shaper_top_defines.svh"
module axis_deadzone_curve_shaper_top
  import adcs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int DIV_STEPS = 17;
  localparam int ST_IN     = 0;
  localparam int ST_SETUP  = 1;
  localparam int ST_DIV0   = 2;
  localparam int ST_RSCALE = ST_DIV0 + DIV_STEPS;
  localparam int ST_LREAD  = ST_RSCALE + 1;
  localparam int ST_LINT   = ST_LREAD + 1;
  localparam int ST_NLOG   = ST_LINT + 1;
  localparam int ST_MULE   = ST_NLOG + 1;
  localparam int ST_EREAD  = ST_MULE + 1;
  localparam int ST_EINT   = ST_EREAD + 1;
  localparam int ST_PSEL   = ST_EINT + 1;
  localparam int ST_GAIN   = ST_PSEL + 1;
  localparam int LANES     = ST_GAIN + 1;

  typedef struct packed {
    logic              neg;
    logic [3:0]        tag;
    logic              dz;
    logic [16:0]       u;
    logic [33:0]       rem;
    logic [16:0]       den;
    logic [16:0]       quo;
    logic [16:0]       r;
    logic [4:0]        sh;
    logic [15:0]       mant;
    logic [TAB_W-1:0]  ta;
    logic [TAB_W-1:0]  tb;
    logic [15:0]       w;
    logic [16:0]       lf;
    logic [20:0]       neglog;
    logic [24:0]       t;
    logic [8:0]        ip;
    logic              fz;
    logic [TAB_W-1:0]  v;
    logic [16:0]       p;
    logic [32:0]       prod;
  } lane_t;

  // Configuration registers
  logic [15:0] deadzone_q, sensitivity_q, curve_exp_q;
  logic        curve_en_q;

  lane_t     stg_q [LANES];
  lane_t     stg_d [LANES];
  logic      vld_q [LANES];
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic      advance;

  logic [TAB_W-1:0] log_rom [TAB_LEN];
  logic [TAB_W-1:0] exp_rom [TAB_LEN];

  // Build the constant curve tables
  for (genvar gi = 0; gi < TAB_LEN; gi++) begin : g_rom
    localparam logic [TAB_W-1:0] LogVal = log_entry(gi);
    localparam logic [TAB_W-1:0] ExpVal = exp_entry(gi);
    assign log_rom[gi] = LogVal;
    assign exp_rom[gi] = ExpVal;
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q    <= DEADZONE_RST;
      sensitivity_q <= SENSITIVITY_RST;
      curve_exp_q   <= CURVE_EXP_RST;
      curve_en_q    <= CURVE_EN_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_DEADZONE:    deadzone_q    <= cfg_wdata_i;
        CFG_SENSITIVITY: sensitivity_q <= cfg_wdata_i;
        CFG_CURVE_EXP:   curve_exp_q   <= cfg_wdata_i;
        CFG_CURVE_EN:    curve_en_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless the output register is full and stalled
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // Stage logic
  always_comb begin
    logic signed [SAMPLE_BITS:0] sx;
    logic [SAMPLE_BITS:0]        m;
    logic [33:0]                 dsh;
    logic [16:0]                 rr;
    logic [4:0]                  k;
    logic [16:0]                 g;
    logic [9:0]                  ip2;
    logic [36:0]                 tprod;
    logic [SAMPLE_BITS+33:0]     magw;
    logic [SAMPLE_BITS-1:0]      mag;
    lane_t                       s;

    for (int i = 1; i < LANES; i++) stg_d[i] = stg_q[i-1];
    stg_d[ST_IN] = '0;

    // Take the magnitude and scale it to Q1.16
    sx = {in_data_i.axis_value[SAMPLE_BITS-1], in_data_i.axis_value};
    m  = sx[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-sx) : (SAMPLE_BITS+1)'(sx);
    stg_d[ST_IN].neg = sx[SAMPLE_BITS];
    stg_d[ST_IN].tag = in_data_i.axis_index;
    stg_d[ST_IN].u   = 17'(({16'd0, m, 16'd0}) >> (SAMPLE_BITS - 1));

    // Compare with the deadzone and set up the division
    s = stg_q[ST_IN];
    stg_d[ST_SETUP].dz  = s.u < {1'b0, deadzone_q};
    stg_d[ST_SETUP].den = 17'(17'd65536 - {1'b0, deadzone_q});
    stg_d[ST_SETUP].rem = (34'(17'(s.u - {1'b0, deadzone_q})) << 16)
                          + 34'(stg_d[ST_SETUP].den >> 1);
    stg_d[ST_SETUP].quo = '0;

    // Restoring division, one quotient bit per stage
    for (int j = 0; j < DIV_STEPS; j++) begin
      s   = stg_q[ST_SETUP + j];
      dsh = 34'(s.den) << (DIV_STEPS - 1 - j);
      if (s.rem >= dsh) begin
        stg_d[ST_DIV0 + j].rem = s.rem - dsh;
        stg_d[ST_DIV0 + j].quo[DIV_STEPS - 1 - j] = 1'b1;
      end
    end

    // Clamp the ratio and normalize it for the log lookup
    s  = stg_q[ST_RSCALE - 1];
    rr = (s.quo > 17'd65536) ? 17'd65536 : s.quo;
    k  = '0;
    for (int b = 1; b < 17; b++) begin
      if (rr[b]) k = 5'(b);
    end
    stg_d[ST_RSCALE].r    = rr;
    stg_d[ST_RSCALE].sh   = 5'(5'd16 - k);
    stg_d[ST_RSCALE].mant = 16'(33'(rr) << (5'd16 - k));

    // Read the log table
    s = stg_q[ST_RSCALE];
    stg_d[ST_LREAD].ta = log_rom[tab_idx(s.mant)];
    stg_d[ST_LREAD].tb = log_rom[IDX_W'(tab_idx(s.mant) + 1'b1)];
    stg_d[ST_LREAD].w  = tab_wt(s.mant);

    // Interpolate the log
    s = stg_q[ST_LREAD];
    stg_d[ST_LINT].lf = 17'(interp(s.ta, s.tb, s.w));

    // Form minus log2 of the ratio
    s = stg_q[ST_LINT];
    stg_d[ST_NLOG].neglog = 21'({s.sh, 16'd0}) - 21'(s.lf);

    // Scale by the exponent, round to nearest
    s     = stg_q[ST_NLOG];
    tprod = 37'(s.neglog) * 37'(curve_exp_q) + 37'd2048;
    stg_d[ST_MULE].t = 25'(tprod >> 12);

    // Split the exponent and read the exp table
    s = stg_q[ST_MULE];
    g = 17'(17'd65536 - {1'b0, s.t[15:0]});
    stg_d[ST_EREAD].ip = s.t[24:16];
    stg_d[ST_EREAD].fz = (s.t[15:0] == 16'd0);
    stg_d[ST_EREAD].ta = exp_rom[tab_idx(g[15:0])];
    stg_d[ST_EREAD].tb = exp_rom[IDX_W'(tab_idx(g[15:0]) + 1'b1)];
    stg_d[ST_EREAD].w  = tab_wt(g[15:0]);

    // Interpolate the power
    s = stg_q[ST_EREAD];
    stg_d[ST_EINT].v = interp(s.ta, s.tb, s.w);

    // Select the shaped magnitude
    s   = stg_q[ST_EINT];
    ip2 = 10'(s.ip) + 10'd1;
    if (!curve_en_q) begin
      stg_d[ST_PSEL].p = s.r;
    end else if (s.r == 17'd0) begin
      stg_d[ST_PSEL].p = '0;
    end else if (curve_exp_q == 16'd0) begin
      stg_d[ST_PSEL].p = 17'd65536;
    end else if (s.fz) begin
      stg_d[ST_PSEL].p = (s.ip >= 9'd17) ? 17'd0 : (17'd65536 >> s.ip);
    end else begin
      stg_d[ST_PSEL].p = (ip2 >= 10'd32) ? 17'd0 : 17'(s.v >> ip2);
    end

    // Apply the gain
    s = stg_q[ST_PSEL];
    stg_d[ST_GAIN].prod = 33'(s.p) * 33'(sensitivity_q);

    // Round, saturate and restore the sign
    s    = stg_q[ST_GAIN];
    magw = ((SAMPLE_BITS+34)'(s.prod) << (SAMPLE_BITS - 1)) + ((SAMPLE_BITS+34)'(1) << 29);
    magw = magw >> 30;
    out_d.axis_tag = s.tag;
    out_d.clipped  = !s.dz && (magw >= (SAMPLE_BITS+34)'(FULL_SCALE));
    if (s.dz) begin
      mag = '0;
    end else if (out_d.clipped) begin
      mag = SAMPLE_BITS'(MAX_MAG);
    end else begin
      mag = magw[SAMPLE_BITS-1:0];
    end
    out_d.shaped_value = s.neg ? $signed(SAMPLE_BITS'(-mag)) : $signed(mag);
  end

  // Move valid bits along the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) vld_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < LANES; i++) vld_q[i] <= vld_q[i-1];
      out_valid_q <= vld_q[LANES-1];
    end
  end

  // Move payload along the pipe
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < LANES; i++) stg_q[i] <= stg_d[i];
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `ADCS_ASSERT_IMPL(a_div_rem_bound, vld_q[ST_RSCALE-1] && !stg_q[ST_RSCALE-1].dz, stg_q[ST_RSCALE-1].rem < 34'(stg_q[ST_RSCALE-1].den), "divider remainder not below divisor")
  `ADCS_ASSERT_IMPL(a_clip_full_scale, out_valid_o && out_data_o.clipped, out_data_o.shaped_value == SAMPLE_BITS'(MAX_MAG) || out_data_o.shaped_value == SAMPLE_BITS'(-MAX_MAG), "clipped result not at full scale")
  `ADCS_ASSERT_NEXT(a_deadzone_zero, advance && vld_q[LANES-1] && stg_q[LANES-1].dz, out_valid_o && out_data_o.shaped_value == '0 && !out_data_o.clipped, "deadzone sample gave nonzero result")

endmodule

>>> test/tb_axis_deadzone_curve_shaper_top.sv
// Testbench for the axis deadzone and response-curve shaper with a built-in shaping predictor.
`timescale 1ns / 1ps
module tb_axis_deadzone_curve_shaper_top;
  import adcs_pkg::*;

  localparam int          STALL_LIMIT  = 3000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PHASES       = 9;
  localparam int          PHASE_ITEMS  = 158;
  localparam logic [2:0]  UNMAPPED_REG = 3'd5;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  axis_deadzone_curve_shaper_top uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shaper settings as the block should hold them
  longint unsigned dz_q = DEADZONE_RST, gain_q = SENSITIVITY_RST;
  longint unsigned expo_q = CURVE_EXP_RST, curve_on = CURVE_EN_RST;

  longint unsigned log2_rom [CURVE_TABLE_ENTRIES+1];
  longint unsigned exp2_rom [CURVE_TABLE_ENTRIES+1];

  in_item_t  pending_samples [$];
  out_item_t shaped_due [$];
  int        mismatches = 0;
  int        shaped_seen = 0;
  int        drive_gap = 0, sink_gap = 0, sink_hold = 0;
  bit        hold_done = 0, steady_flow = 0;
  int        quiet_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Build log2(1+f) and 2^f tables in Q.16
  function automatic void fill_curve_roms();
    longint unsigned roots [24];
    longint unsigned x, res, q, v;
    roots[0] = int_sqrt(64'd1 << 61);
    for (int j = 1; j < 24; j++) roots[j] = int_sqrt(roots[j-1] << 30);
    for (int i = 0; i <= CURVE_TABLE_ENTRIES; i++) begin
      if (i == CURVE_TABLE_ENTRIES) begin
        log2_rom[i] = 65536;
        exp2_rom[i] = 131072;
      end else begin
        x = (64'd1 << 30) + ((longint'(i) << 30) / CURVE_TABLE_ENTRIES);
        res = 0;
        for (int j = 0; j < 20; j++) begin
          x = (x * x) >> 30;
          res <<= 1;
          if (x >= (64'd1 << 31)) begin
            res |= 1;
            x >>= 1;
          end
        end
        log2_rom[i] = (res + 8) >> 4;
        q = (longint'(i) << 24) / CURVE_TABLE_ENTRIES;
        v = 64'd1 << 30;
        for (int j = 0; j < 24; j++) if (q[23-j]) v = (v * roots[j]) >> 30;
        exp2_rom[i] = (v + (64'd1 << 13)) >> 14;
      end
    end
  endfunction

  function automatic longint unsigned rom_interp(bit use_exp, longint unsigned frac);
    longint unsigned pos, idx, w, a, b;
    pos = frac * CURVE_TABLE_ENTRIES;
    idx = pos >> 16;
    w = pos & 64'hFFFF;
    if (idx >= CURVE_TABLE_ENTRIES) idx = CURVE_TABLE_ENTRIES - 1;
    a = use_exp ? exp2_rom[idx] : log2_rom[idx];
    b = use_exp ? exp2_rom[idx+1] : log2_rom[idx+1];
    if (b < a) b = a;
    return a + (((b - a) * w) >> 16);
  endfunction

  // r^e with r in Q1.16 and e in Q4.12
  function automatic longint unsigned raise_to_exponent(longint unsigned r, longint unsigned e);
    int k;
    longint unsigned neglog, t, ip, fp, v;
    k = 16;
    while (k > 0 && r[k] == 1'b0) k--;
    neglog = longint'(16 - k) * 65536 - rom_interp(0, (r << (16 - k)) & 64'hFFFF);
    t = (neglog * e + 2048) >> 12;
    ip = t >> 16;
    fp = t & 64'hFFFF;
    if (fp == 0) return (ip >= 17) ? 0 : (64'd65536 >> ip);
    ip += 1;
    v = rom_interp(1, 65536 - fp);
    return (ip >= 32) ? 0 : (v >> ip);
  endfunction

  function automatic out_item_t shape_sample(in_item_t s);
    out_item_t o;
    longint unsigned raw, m, u, den, r, p, mag;
    bit neg;
    raw = 64'(unsigned'(s.axis_value));
    neg = raw[15];
    m = neg ? ((65536 - raw) & 64'hFFFF) : raw;
    if (neg && m == 0) m = FULL_SCALE;
    u = (m << 16) >> (SAMPLE_BITS - 1);
    mag = 0;
    o.clipped = 1'b0;
    if (u >= dz_q) begin
      den = 65536 - dz_q;
      r = (((u - dz_q) << 16) + (den >> 1)) / den;
      if (r > 65536) r = 65536;
      if (curve_on != 0) begin
        if (r == 0) p = 0;
        else if (expo_q == 0) p = 65536;
        else p = raise_to_exponent(r, expo_q);
      end else begin
        p = r;
      end
      mag = (p * gain_q * FULL_SCALE + (64'd1 << 29)) >> 30;
      if (mag >= FULL_SCALE) begin
        mag = MAX_MAG;
        o.clipped = 1'b1;
      end
    end
    o.shaped_value = neg ? -16'(mag) : 16'(mag);
    o.axis_tag = s.axis_index;
    return o;
  endfunction

  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // Offer queued samples; predict each transaction as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) shaped_due.push_back(shape_sample(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (drive_gap > 0) begin
          drive_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_data_i <= pending_samples.pop_front();
          in_valid_i <= 1'b1;
          drive_gap = steady_flow ? 0 : draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check shaped results in order and pace the output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        shaped_seen++;
        if (shaped_due.size() == 0) begin
          $error("unexpected result: shaped_value %0d", out_data_o.shaped_value);
          mismatches++;
        end else begin
          out_item_t want;
          want = shaped_due.pop_front();
          if (out_data_o.shaped_value !== want.shaped_value) begin
            $error("shaped_value: expected %0d, got %0d", want.shaped_value,
                   out_data_o.shaped_value);
            mismatches++;
          end
          if (out_data_o.axis_tag !== want.axis_tag) begin
            $error("axis_tag: expected %0d, got %0d", want.axis_tag, out_data_o.axis_tag);
            mismatches++;
          end
          if (out_data_o.clipped !== want.clipped) begin
            $error("clipped: expected %0d, got %0d", want.clipped, out_data_o.clipped);
            mismatches++;
          end
        end
      end
      // Hold off once for a long stretch so the pipe fills and backs up
      if (!hold_done && shaped_seen >= 300) begin
        hold_done = 1;
        sink_hold = 400;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready_i <= 1'b0;
      end else if (steady_flow) begin
        out_ready_i <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_gap = draw_gap();
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("axis_deadzone_curve_shaper_top regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_DEADZONE:    dz_q = val;
      CFG_SENSITIVITY: gain_q = val;
      CFG_CURVE_EXP:   expo_q = val;
      CFG_CURVE_EN:    curve_on = val[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [15:0] dz, logic [15:0] gain, logic [15:0] expo,
                               logic en);
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_SENSITIVITY, gain);
    write_reg(CFG_CURVE_EXP, expo);
    write_reg(CFG_CURVE_EN, {15'($urandom), en});
    write_reg(UNMAPPED_REG, 16'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid_i || shaped_due.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_sample();
    in_item_t s;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) s.axis_value = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
    else if (pick == 1) s.axis_value = 16'($urandom_range(0, 64)) - 16'sd32;
    else s.axis_value = 16'($urandom);
    s.axis_index = 4'($urandom);
    return s;
  endfunction

  initial begin
    in_item_t s;
    logic signed [15:0] corner [12];
    corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1, 16'sh8001,
               16'sh4000, -16'sh4000, 16'sd2, 16'sh5555, -16'sh2AAA, 16'sh0100};
    fill_curve_roms();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: extremes, zero and every axis tag
    for (int i = 0; i < 24; i++) begin
      s.axis_value = corner[i % 12];
      s.axis_index = 4'(i);
      pending_samples.push_back(s);
    end
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_settings(16'd0, 16'hFFFF, 16'd4096, 1'b1);
        1: load_settings(16'hFFFF, 16'd0, 16'd1, 1'b0);
        2: load_settings(16'h8000, 16'd16384, 16'hFFFF, 1'b1);
        3: load_settings(16'hFFFE, 16'hFFFF, 16'd1, 1'b1);
        4: load_settings(16'd3000, 16'd20480, 16'd4819, 1'b0);
        default: load_settings(16'($urandom_range(0, 20000)), 16'($urandom),
                               16'($urandom_range(1, 65535)), 1'($urandom));
      endcase
      steady_flow = (ph == 4);
      // Samples just at and around the deadzone edge
      for (int i = 0; i < 4; i++) begin
        s.axis_value = 16'(((dz_q >> 1) + i - 1) & 16'h7FFF);
        if (i[0]) s.axis_value = -s.axis_value;
        s.axis_index = 4'($urandom);
        pending_samples.push_back(s);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) pending_samples.push_back(rand_sample());
      drain();
    end

    if (mismatches == 0)
      $display("axis_deadzone_curve_shaper_top regression: pass");
    else
      $display("axis_deadzone_curve_shaper_top regression: fail");
    $finish;
  end

endmodule
